// ===== hdl/random_permutation_shuffler_unit_assert.svh =====
// Assertion macros for the random permutation shuffler.
`ifndef RANDOM_PERMUTATION_SHUFFLER_UNIT_ASSERT_SVH
`define RANDOM_PERMUTATION_SHUFFLER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// Checks a property at every rising edge outside reset.
`define RPSU_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("rpsu assertion failed");

// Checks that a condition in the next cycle follows from an antecedent.
`define RPSU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("rpsu assertion failed");

`else

`define RPSU_ASSERT(lbl, clk, rstn, prop)
`define RPSU_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== hdl/rpsu_pkg.sv =====
// Shared constants and types of the random permutation shuffler.
package rpsu_pkg;

	localparam int WORD_W = 31;
	localparam int POS_W = 10;
	localparam int ELEM_W = 11;
	localparam int SIZE_W = 11;
	localparam int MAX_ELEMENTS_DEF = 1024;
	localparam logic [SIZE_W-1:0] PERM_SIZE_RESET = 11'd1024;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLR,
		ST_DIV,
		ST_RDJ,
		ST_WRJ,
		ST_WRI,
		ST_OUTW
	} rpsu_state_t;

endpackage

// ===== hdl/rpsu_if.sv =====
// Valid/ready channel interfaces for the random words and the permutation entries.
interface rpsu_in_if;
	logic valid;
	logic ready;
	logic [rpsu_pkg::WORD_W-1:0] random_word;

	modport source(output valid, output random_word, input ready);
	modport sink(input valid, input random_word, output ready);
endinterface

interface rpsu_out_if;
	logic valid;
	logic ready;
	logic [rpsu_pkg::POS_W-1:0] position;
	logic [rpsu_pkg::ELEM_W-1:0] element;
	logic last;

	modport source(output valid, output position, output element, output last, input ready);
	modport sink(input valid, input position, input element, input last, output ready);
endinterface

// ===== hdl/random_permutation_shuffler_unit.sv =====
// Top level of the random permutation shuffler (forward Fisher-Yates).
//
// The items channel takes one 31-bit random word per transfer; each word yields
// exactly one transfer on the results channel carrying a position, the final
// element at that position and a last flag that marks the end of a permutation.
// perm_size is written through cfg_we/cfg_wdata; the user must write it only while
// the block is idle, as the block itself does not enforce this. From its transfer
// to its result each item passes through an accept step, 31 iterations of the
// shared compare-and-subtract unit that reduces the word modulo the remaining
// count, the steps on the single port pair of the element RAM (read j, write j,
// write i) and the load of the output register. items.ready is high only while
// the block idles. Each element RAM entry carries a written flag. After the last
// entry of a permutation the block sweeps the flags clear, one entry per cycle,
// over the highest index written; after reset it sweeps all MAX_ELEMENTS entries
// before it accepts the first item. Configuration writes are always taken. A
// stalled results channel holds its entry; the block may meanwhile accept and work
// on the next item, but waits for the transfer before it loads the next result.
module random_permutation_shuffler_unit #(
	parameter int MAX_ELEMENTS = rpsu_pkg::MAX_ELEMENTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [rpsu_pkg::SIZE_W-1:0] cfg_wdata,
	rpsu_in_if.sink                     items,
	rpsu_out_if.source                  results
);

	localparam int ADDR_W = $clog2(MAX_ELEMENTS);
	localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
	localparam int RAM_W = CNT_W + 1;
	localparam int DCNT_W = $clog2(rpsu_pkg::WORD_W);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ELEMENTS);
	localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

	rpsu_pkg::rpsu_state_t state_q, state_d;

	logic [rpsu_pkg::SIZE_W-1:0] perm_size_q;
	logic [ADDR_W-1:0]           pos_q;
	logic [CNT_W-1:0]            hw_q;
	logic [ADDR_W-1:0]           clr_q;
	logic                        pend_q;
	logic                        out_valid_q;

	logic [rpsu_pkg::WORD_W-1:0] word_q;
	logic [CNT_W-1:0]            n_q;
	logic [CNT_W-1:0]            m_q;
	logic [CNT_W-1:0]            rem_q;
	logic [DCNT_W-1:0]           dcnt_q;
	logic [ADDR_W-1:0]           j_q;
	logic [CNT_W-1:0]            vi_q;
	logic [CNT_W-1:0]            vj_q;
	logic [rpsu_pkg::POS_W-1:0]  position_q;
	logic [rpsu_pkg::ELEM_W-1:0] element_q;
	logic                        last_q;

	logic [CNT_W-1:0]  n_eff;
	logic              accept;
	logic              restart;
	logic [CNT_W:0]    sh;
	logic [CNT_W-1:0]  rem_nx;
	logic              clr_done;
	logic              out_free;
	logic              last_w;
	logic [ADDR_W-1:0] j_w;
	logic [CNT_W-1:0]  j_inc;
	logic [CNT_W-1:0]  rd_val_i;
	logic [CNT_W-1:0]  rd_val_j;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [RAM_W-1:0]  ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [RAM_W-1:0]  ram_rdata;

	rpsu_ram #(
		.WIDTH(RAM_W),
		.DEPTH(MAX_ELEMENTS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// A size of zero acts as one; a size above the store depth saturates.
	always_comb begin
		if (perm_size_q == '0) begin
			n_eff = ONE_CNT;
		end else if (32'(perm_size_q) > 32'(MAX_ELEMENTS)) begin
			n_eff = MAX_CNT;
		end else begin
			n_eff = CNT_W'(perm_size_q);
		end
	end

	assign accept = items.valid && items.ready;
	assign restart = CNT_W'(pos_q) >= n_eff;
	assign out_free = !out_valid_q || results.ready;
	assign last_w = (CNT_W'(pos_q) + ONE_CNT) == n_q;
	assign clr_done = (hw_q == '0) || ((CNT_W'(clr_q) + ONE_CNT) >= hw_q);

	// One restoring step of the remainder: bring in the next word bit, subtract if it fits.
	assign sh = {rem_q, word_q[rpsu_pkg::WORD_W-1]};
	assign rem_nx = (sh >= {1'b0, m_q}) ? CNT_W'(sh - {1'b0, m_q}) : CNT_W'(sh);

	assign j_w = ADDR_W'(CNT_W'(pos_q) + rem_q);
	assign j_inc = CNT_W'(j_q) + ONE_CNT;

	// An entry without its written flag reads as its index plus one.
	assign rd_val_i = ram_rdata[RAM_W-1] ? ram_rdata[CNT_W-1:0] : CNT_W'(pos_q) + ONE_CNT;
	assign rd_val_j = ram_rdata[RAM_W-1] ? ram_rdata[CNT_W-1:0] : CNT_W'(j_q) + ONE_CNT;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rpsu_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = restart ? rpsu_pkg::ST_CLR : rpsu_pkg::ST_DIV;
				end
			end
			rpsu_pkg::ST_CLR: begin
				if (clr_done) begin
					state_d = pend_q ? rpsu_pkg::ST_DIV : rpsu_pkg::ST_IDLE;
				end
			end
			rpsu_pkg::ST_DIV: begin
				if (dcnt_q == '0) begin
					state_d = rpsu_pkg::ST_RDJ;
				end
			end
			rpsu_pkg::ST_RDJ: state_d = rpsu_pkg::ST_WRJ;
			rpsu_pkg::ST_WRJ: state_d = rpsu_pkg::ST_WRI;
			rpsu_pkg::ST_WRI: state_d = rpsu_pkg::ST_OUTW;
			rpsu_pkg::ST_OUTW: begin
				if (out_free) begin
					state_d = last_w ? rpsu_pkg::ST_CLR : rpsu_pkg::ST_IDLE;
				end
			end
			default: state_d = rpsu_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		items.ready = 1'b0;
		ram_we = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = '0;
		ram_raddr = pos_q;
		unique case (state_q)
			rpsu_pkg::ST_IDLE: items.ready = 1'b1;
			rpsu_pkg::ST_CLR: begin
				ram_we = hw_q != '0;
				ram_waddr = clr_q;
			end
			rpsu_pkg::ST_DIV: ram_raddr = pos_q;
			rpsu_pkg::ST_RDJ: ram_raddr = j_w;
			rpsu_pkg::ST_WRJ: begin
				ram_we = 1'b1;
				ram_waddr = j_q;
				ram_wdata = {1'b1, vi_q};
			end
			rpsu_pkg::ST_WRI: begin
				ram_we = 1'b1;
				ram_waddr = pos_q;
				ram_wdata = {1'b1, vj_q};
			end
			rpsu_pkg::ST_OUTW: ram_raddr = pos_q;
			default: items.ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rpsu_pkg::ST_CLR;
			perm_size_q <= rpsu_pkg::PERM_SIZE_RESET;
			pos_q <= '0;
			hw_q <= MAX_CNT;
			clr_q <= '0;
			pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				perm_size_q <= cfg_wdata;
			end
			if (accept && restart) begin
				pend_q <= 1'b1;
				pos_q <= '0;
			end
			if (state_q == rpsu_pkg::ST_CLR) begin
				if (clr_done) begin
					hw_q <= '0;
					clr_q <= '0;
					pend_q <= 1'b0;
				end else begin
					clr_q <= clr_q + ADDR_W'(1);
				end
			end
			if (state_q == rpsu_pkg::ST_WRJ && j_inc > hw_q) begin
				hw_q <= j_inc;
			end
			if (state_q == rpsu_pkg::ST_OUTW && out_free) begin
				out_valid_q <= 1'b1;
				pos_q <= last_w ? '0 : pos_q + ADDR_W'(1);
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_q <= items.random_word;
			n_q <= n_eff;
			m_q <= restart ? n_eff : n_eff - CNT_W'(pos_q);
			rem_q <= '0;
			dcnt_q <= DCNT_W'(rpsu_pkg::WORD_W - 1);
		end
		if (state_q == rpsu_pkg::ST_DIV) begin
			rem_q <= rem_nx;
			word_q <= word_q << 1;
			dcnt_q <= dcnt_q - DCNT_W'(1);
		end
		if (state_q == rpsu_pkg::ST_RDJ) begin
			j_q <= j_w;
			vi_q <= rd_val_i;
		end
		if (state_q == rpsu_pkg::ST_WRJ) begin
			vj_q <= rd_val_j;
		end
		if (state_q == rpsu_pkg::ST_OUTW && out_free) begin
			position_q <= rpsu_pkg::POS_W'(pos_q);
			element_q <= rpsu_pkg::ELEM_W'(vj_q);
			last_q <= last_w;
		end
	end

	assign results.valid = out_valid_q;
	assign results.position = position_q;
	assign results.element = element_q;
	assign results.last = last_q;

`include "random_permutation_shuffler_unit_assert.svh"

	`RPSU_ASSERT(a_rem_below_mod, clk, arst_n, (state_q != rpsu_pkg::ST_DIV) || (rem_q < m_q))
	`RPSU_ASSERT(a_pos_in_range, clk, arst_n, (state_q != rpsu_pkg::ST_DIV) || (CNT_W'(pos_q) < n_q))
	`RPSU_ASSERT(a_swap_in_range, clk, arst_n, (state_q != rpsu_pkg::ST_RDJ) || ((CNT_W'(pos_q) + rem_q) < n_q))
	`RPSU_ASSERT_NEXT(a_accept_starts, clk, arst_n, accept, (state_q == rpsu_pkg::ST_DIV) || (state_q == rpsu_pkg::ST_CLR))

endmodule

// ===== hdl/rpsu_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module rpsu_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
